// File: hdl/arpre_pkg.sv
package arpre_pkg;

  localparam int unsigned CACHE_N = 16;
  localparam int unsigned PEND_N  = 8;
  localparam int unsigned PARK_N  = 16;
  localparam int unsigned MAX_RES = 16;

  localparam int unsigned CIW   = $clog2(CACHE_N);
  localparam int unsigned PIW   = $clog2(PEND_N);
  localparam int unsigned PKW   = $clog2(PARK_N);
  localparam int unsigned PCW   = $clog2(PARK_N + 1);
  localparam int unsigned RES_W = $clog2(MAX_RES + 1);
  localparam int unsigned AGE_W = 17;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [47:0] MAC_BCAST = '1;
  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_ARP  = 16'h0806;
  localparam logic [15:0] ARP_OP_REQ = 16'd1;
  localparam logic [15:0] ARP_OP_REP = 16'd2;

  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_RECV = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] KIND_IPV4    = 2'd0;
  localparam logic [1:0] KIND_ARP_REQ = 2'd1;
  localparam logic [1:0] KIND_ARP_REP = 2'd2;
  localparam logic [1:0] KIND_DELIVER = 2'd3;

  localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
  localparam logic [1:0] CFG_OWN_IP   = 2'd1;
  localparam logic [1:0] CFG_CACHE_LF = 2'd2;
  localparam logic [1:0] CFG_PEND_LF  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] next_hop_ip;
    logic [15:0] datagram_tag;
    logic [47:0] frame_dst_mac;
    logic [15:0] frame_ethertype;
    logic        payload_ok;
    logic [15:0] arp_op;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [47:0] dst_mac;
    logic [15:0] ethertype;
    logic [15:0] out_arp_op;
    logic [47:0] out_target_mac;
    logic [31:0] out_target_ip;
    logic [15:0] out_tag;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_S_CACHE, ST_S_PARK, ST_R_FILT, ST_R_LEARN, ST_R_WRITE,
    ST_R_REPLY, ST_R_FLUSH, ST_T_CACHE, ST_T_PEND, ST_T_FLUSH, ST_FINISH
  } state_e;

  typedef struct packed {
    state_e op;
    logic   load;
  } dp_cmd_t;

  typedef struct packed {
    logic             stall;
    logic             hit;
    logic             cache_last;
    logic             pend_last;
    logic             flush_end;
    logic             arp_ok;
    logic             stg_valid;
    logic [RES_W-1:0] res_cnt;
  } dp_sts_t;

endpackage

// File: hdl/arpre_ctrl.sv
module arpre_ctrl import arpre_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic [1:0] req_type_i,
  input  dp_sts_t  sts_i,
  output logic     in_ready_o,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    if (!sts_i.stall) begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            unique case (req_type_i)
              REQ_SEND: state_d = ST_S_CACHE;
              REQ_RECV: state_d = ST_R_FILT;
              REQ_TICK: state_d = ST_T_CACHE;
              default:  state_d = ST_IDLE;
            endcase
          end
        end
        ST_S_CACHE: begin
          if (sts_i.hit) state_d = ST_FINISH;
          else if (sts_i.cache_last) state_d = ST_S_PARK;
        end
        ST_S_PARK: state_d = ST_FINISH;
        ST_R_FILT: begin
          if (sts_i.arp_ok) state_d = ST_R_LEARN;
          else state_d = ST_FINISH;
        end
        ST_R_LEARN: begin
          if (sts_i.cache_last) state_d = ST_R_WRITE;
        end
        ST_R_WRITE: state_d = ST_R_REPLY;
        ST_R_REPLY: state_d = ST_R_FLUSH;
        ST_R_FLUSH: begin
          if (sts_i.flush_end) state_d = ST_FINISH;
        end
        ST_T_CACHE: begin
          if (sts_i.cache_last) state_d = ST_T_PEND;
        end
        ST_T_PEND: begin
          if (sts_i.pend_last) state_d = ST_T_FLUSH;
        end
        ST_T_FLUSH: begin
          if (sts_i.flush_end) state_d = ST_FINISH;
        end
        ST_FINISH: state_d = ST_IDLE;
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    cmd_o.op   = state_q;
    cmd_o.load = in_valid_i && (state_q == ST_IDLE);
  end

endmodule

// File: hdl/arpre_dp.sv
module arpre_dp import arpre_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  in_item_t   in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_sts_t    sts_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o
);

  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q;
  logic [15:0] cache_life_q, pend_life_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q    <= '0;
      own_ip_q     <= '0;
      cache_life_q <= 16'd30000;
      pend_life_q  <= 16'd5000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OWN_MAC:  own_mac_q    <= cfg_data_i;
        CFG_OWN_IP:   own_ip_q     <= cfg_data_i[31:0];
        CFG_CACHE_LF: cache_life_q <= cfg_data_i[15:0];
        CFG_PEND_LF:  pend_life_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  in_item_t in_q;

  logic [31:0]      cache_ip_q  [CACHE_N];
  logic [47:0]      cache_mac_q [CACHE_N];
  logic [AGE_W-1:0] cache_age_q [CACHE_N];
  logic [CACHE_N-1:0] cache_v_q;
  logic [31:0]      pend_ip_q  [PEND_N];
  logic [AGE_W-1:0] pend_age_q [PEND_N];
  logic [PEND_N-1:0] pend_v_q, exp_q;
  logic [15:0]      park_tag_q [PARK_N];
  logic [31:0]      park_ip_q  [PARK_N];

  logic [CIW-1:0]   idx_q;
  logic [PCW-1:0]   cnt_q, rd_q, wr_q;
  logic [RES_W-1:0] res_q;
  logic             lm_f_q, lf_f_q;
  logic [CIW-1:0]   lm_i_q, lf_i_q, lx_i_q;
  logic [AGE_W-1:0] lx_age_q;

  out_item_t stg_q, out_q, emit_item, fin_item;
  logic stg_v_q, out_v_q;

  logic [31:0]      c_ip;
  logic [47:0]      c_mac;
  logic [AGE_W-1:0] c_age, c_new, p_age, p_new;
  logic [AGE_W:0]   c_sum, p_sum;
  logic             c_v, p_v, c_exp, p_exp, hit, lmatch;
  logic [PIW-1:0]   pidx;
  logic             pm, pf, park_ok;
  logic [PIW-1:0]   pf_i;
  logic [15:0]      k_tag;
  logic [31:0]      k_ip;
  logic             flush_end, kmatch_r, kmatch_t, kmatch;
  logic             to_us, pass, deliver, arp_ok, reply_need, room;
  logic [CIW-1:0]   lw;
  logic             can_push, emit_ok, emit_req, finish_req, stall, go;

  always_comb begin
    c_ip   = cache_ip_q[idx_q];
    c_mac  = cache_mac_q[idx_q];
    c_age  = cache_age_q[idx_q];
    c_v    = cache_v_q[idx_q];
    c_sum  = {1'b0, c_age} + {{(AGE_W - 15){1'b0}}, in_q.elapsed_ms};
    c_new  = (c_sum > {1'b0, AGE_MAX}) ? AGE_MAX : c_sum[AGE_W-1:0];
    c_exp  = c_new >= {{(AGE_W - 16){1'b0}}, cache_life_q};
    hit    = c_v && (c_ip == in_q.next_hop_ip);
    lmatch = c_v && (c_ip == in_q.sender_ip);

    pidx  = idx_q[PIW-1:0];
    p_age = pend_age_q[pidx];
    p_v   = pend_v_q[pidx];
    p_sum = {1'b0, p_age} + {{(AGE_W - 15){1'b0}}, in_q.elapsed_ms};
    p_new = (p_sum > {1'b0, AGE_MAX}) ? AGE_MAX : p_sum[AGE_W-1:0];
    p_exp = p_new >= {{(AGE_W - 16){1'b0}}, pend_life_q};

    pm   = 1'b0;
    pf   = 1'b0;
    pf_i = '0;
    for (int k = 0; k < PEND_N; k++) begin
      if (pend_v_q[k] && pend_ip_q[k] == in_q.next_hop_ip) pm = 1'b1;
      if (!pend_v_q[k] && !pf) begin
        pf   = 1'b1;
        pf_i = PIW'(k);
      end
    end
    park_ok = (cnt_q < PCW'(PARK_N)) && (pm || pf);

    k_tag     = park_tag_q[rd_q[PKW-1:0]];
    k_ip      = park_ip_q[rd_q[PKW-1:0]];
    flush_end = (rd_q == cnt_q);
    kmatch_r  = (k_ip == in_q.sender_ip);
    kmatch_t  = 1'b0;
    for (int k = 0; k < PEND_N; k++) begin
      if (exp_q[k] && pend_ip_q[k] == k_ip) kmatch_t = 1'b1;
    end
    kmatch = (cmd_i.op == ST_T_FLUSH) ? kmatch_t : kmatch_r;

    to_us   = (in_q.frame_dst_mac == own_mac_q);
    pass    = to_us || (in_q.frame_dst_mac == MAC_BCAST);
    deliver = to_us && in_q.frame_ethertype == ET_IPV4 && in_q.payload_ok;
    arp_ok  = pass && in_q.frame_ethertype == ET_ARP && in_q.payload_ok &&
              (in_q.arp_op == ARP_OP_REQ || in_q.arp_op == ARP_OP_REP);
    reply_need = (in_q.arp_op == ARP_OP_REQ) && (in_q.target_ip == own_ip_q);
    room = res_q < RES_W'(MAX_RES);
    lw   = lm_f_q ? lm_i_q : (lf_f_q ? lf_i_q : lx_i_q);
  end

  always_comb begin
    emit_item = '0;
    emit_req  = 1'b0;
    unique case (cmd_i.op)
      ST_S_CACHE: begin
        emit_req            = hit;
        emit_item.out_kind  = KIND_IPV4;
        emit_item.dst_mac   = c_mac;
        emit_item.ethertype = ET_IPV4;
        emit_item.out_tag   = in_q.datagram_tag;
      end
      ST_S_PARK: begin
        emit_req                 = park_ok && !pm;
        emit_item.out_kind       = KIND_ARP_REQ;
        emit_item.dst_mac        = MAC_BCAST;
        emit_item.ethertype      = ET_ARP;
        emit_item.out_arp_op     = ARP_OP_REQ;
        emit_item.out_target_ip  = in_q.next_hop_ip;
      end
      ST_R_FILT: begin
        emit_req            = deliver;
        emit_item.out_kind  = KIND_DELIVER;
        emit_item.ethertype = ET_IPV4;
        emit_item.out_tag   = in_q.datagram_tag;
      end
      ST_R_REPLY: begin
        emit_req                 = reply_need;
        emit_item.out_kind       = KIND_ARP_REP;
        emit_item.dst_mac        = in_q.sender_mac;
        emit_item.ethertype      = ET_ARP;
        emit_item.out_arp_op     = ARP_OP_REP;
        emit_item.out_target_mac = in_q.sender_mac;
        emit_item.out_target_ip  = in_q.sender_ip;
      end
      ST_R_FLUSH: begin
        emit_req            = !flush_end && kmatch;
        emit_item.out_kind  = KIND_IPV4;
        emit_item.dst_mac   = in_q.sender_mac;
        emit_item.ethertype = ET_IPV4;
        emit_item.out_tag   = k_tag;
      end
      default: ;
    endcase
    emit_req   = emit_req && room;
    finish_req = (cmd_i.op == ST_FINISH) && stg_v_q;
    can_push   = !out_v_q || out_ready_i;
    emit_ok    = !stg_v_q || can_push;
    stall      = (emit_req && !emit_ok) || (finish_req && !can_push);
    go         = !stall;
    fin_item      = stg_q;
    fin_item.last = 1'b1;
  end

  // Result staging: a result is held back one place so that the final one can be flagged.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      stg_v_q <= 1'b0;
    end else begin
      if (emit_req && emit_ok) begin
        stg_v_q <= 1'b1;
        if (stg_v_q) begin
          out_v_q <= 1'b1;
        end else if (out_ready_i) begin
          out_v_q <= 1'b0;
        end
      end else if (finish_req && can_push) begin
        out_v_q <= 1'b1;
        stg_v_q <= 1'b0;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_req && emit_ok) begin
      if (stg_v_q) out_q <= stg_q;
      stg_q <= emit_item;
    end else if (finish_req && can_push) begin
      out_q <= fin_item;
    end
  end

  // Control state of the sequencer's datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_v_q <= '0;
      pend_v_q  <= '0;
      exp_q     <= '0;
      idx_q     <= '0;
      cnt_q     <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      res_q     <= '0;
      lm_f_q    <= 1'b0;
      lf_f_q    <= 1'b0;
      lm_i_q    <= '0;
      lf_i_q    <= '0;
      lx_i_q    <= '0;
      lx_age_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
        rd_q  <= '0;
        wr_q  <= '0;
        res_q <= '0;
        exp_q <= '0;
      end else begin
        if (emit_req && emit_ok) res_q <= res_q + RES_W'(1);
        if (go) begin
          unique case (cmd_i.op) inside
            ST_S_CACHE, ST_T_CACHE: begin
              idx_q <= (idx_q == CIW'(CACHE_N - 1)) ? '0 : idx_q + CIW'(1);
              if (cmd_i.op == ST_T_CACHE && c_v && c_exp) cache_v_q[idx_q] <= 1'b0;
            end
            ST_S_PARK: begin
              if (park_ok) begin
                cnt_q <= cnt_q + PCW'(1);
                if (!pm) pend_v_q[pf_i] <= 1'b1;
              end
            end
            ST_R_LEARN: begin
              idx_q <= (idx_q == CIW'(CACHE_N - 1)) ? '0 : idx_q + CIW'(1);
              if (idx_q == '0) begin
                lm_f_q   <= lmatch;
                lm_i_q   <= '0;
                lf_f_q   <= !c_v;
                lf_i_q   <= '0;
                lx_i_q   <= '0;
                lx_age_q <= c_age;
              end else begin
                if (!lm_f_q && lmatch) begin
                  lm_f_q <= 1'b1;
                  lm_i_q <= idx_q;
                end
                if (!lf_f_q && !c_v) begin
                  lf_f_q <= 1'b1;
                  lf_i_q <= idx_q;
                end
                if (c_age > lx_age_q) begin
                  lx_i_q   <= idx_q;
                  lx_age_q <= c_age;
                end
              end
            end
            ST_R_WRITE: begin
              cache_v_q[lw] <= 1'b1;
              for (int k = 0; k < PEND_N; k++) begin
                if (pend_ip_q[k] == in_q.sender_ip) pend_v_q[k] <= 1'b0;
              end
            end
            ST_T_PEND: begin
              idx_q <= (pidx == PIW'(PEND_N - 1)) ? '0 : idx_q + CIW'(1);
              if (p_v && p_exp) begin
                pend_v_q[pidx] <= 1'b0;
                exp_q[pidx]    <= 1'b1;
              end
            end
            ST_R_FLUSH, ST_T_FLUSH: begin
              if (flush_end) begin
                cnt_q <= wr_q;
              end else begin
                rd_q <= rd_q + PCW'(1);
                if (!kmatch) wr_q <= wr_q + PCW'(1);
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Table contents.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end else if (go) begin
      unique case (cmd_i.op) inside
        ST_T_CACHE: begin
          if (c_v) cache_age_q[idx_q] <= c_new;
        end
        ST_S_PARK: begin
          if (park_ok) begin
            park_tag_q[cnt_q[PKW-1:0]] <= in_q.datagram_tag;
            park_ip_q[cnt_q[PKW-1:0]]  <= in_q.next_hop_ip;
            if (!pm) begin
              pend_ip_q[pf_i]  <= in_q.next_hop_ip;
              pend_age_q[pf_i] <= '0;
            end
          end
        end
        ST_R_WRITE: begin
          cache_ip_q[lw]  <= in_q.sender_ip;
          cache_mac_q[lw] <= in_q.sender_mac;
          cache_age_q[lw] <= '0;
        end
        ST_T_PEND: begin
          if (p_v) pend_age_q[pidx] <= p_new;
        end
        ST_R_FLUSH, ST_T_FLUSH: begin
          if (!flush_end && !kmatch) begin
            park_tag_q[wr_q[PKW-1:0]] <= k_tag;
            park_ip_q[wr_q[PKW-1:0]]  <= k_ip;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts_o.stall      = stall;
    sts_o.hit        = hit;
    sts_o.cache_last = (idx_q == CIW'(CACHE_N - 1));
    sts_o.pend_last  = (pidx == PIW'(PEND_N - 1));
    sts_o.flush_end  = flush_end;
    sts_o.arp_ok     = arp_ok;
    sts_o.stg_valid  = stg_v_q;
    sts_o.res_cnt    = res_q;
    out_valid_o      = out_v_q;
    out_data_o       = out_q;
  end

endmodule

// File: hdl/arp_resolution_engine.sv
// ARP resolution engine. Each transfer on the input channel is a datagram to send, a received
// frame or a time tick; the engine answers with zero to sixteen result transfers, the final one
// flagged by last. Items are handled one at a time: the input is ready only while the sequencer
// is idle. A send searches the cache entry by entry and finishes on a hit; on a miss it tries
// to park the datagram, then finishes. A received ARP message passes through filter, cache
// learning, write, reply, flush of the parked datagrams and finish; any other received frame
// through filter and finish. A tick passes through cache ageing, pending ageing, flush of the
// parked datagrams and finish. The cache and pending tables are walked one entry a cycle, and a
// result waiting on a stalled output holds the sequencer. Configuration is to be written through
// cfg_we_i, cfg_idx_i and cfg_data_i while the engine is idle; the block does not enforce this.
module arp_resolution_engine import arpre_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences the phases of each item; the datapath owns the tables.
  arpre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  arpre_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // When a new item may be taken, no result of the previous one may still be staged.
  a_idle_no_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.stg_valid)
    else $error("staged result left behind when idle");

  // The result count never passes the limit of sixteen.
  a_res_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.res_cnt <= RES_W'(MAX_RES))
    else $error("result count overflow");
`endif

endmodule

// File: bench/tb_arp_resolution_engine.sv
`timescale 1ns / 1ps

// Expected-result store for the resolution engine. Each accepted item is run
// through a predictor of the cache, pending and parked tables, and the
// results it gives are queued; each transfer on the output is then checked
// against the oldest of them.
class arp_result_board;
  logic [47:0] mac_own;
  logic [31:0] ip_own;
  logic [15:0] cache_lf;
  logic [15:0] pend_lf;

  logic [31:0] c_ip [arpre_pkg::CACHE_N];
  logic [47:0] c_mac[arpre_pkg::CACHE_N];
  int unsigned c_age[arpre_pkg::CACHE_N];
  bit          c_vld[arpre_pkg::CACHE_N];
  logic [31:0] p_ip [arpre_pkg::PEND_N];
  int unsigned p_age[arpre_pkg::PEND_N];
  bit          p_vld[arpre_pkg::PEND_N];
  logic [15:0] k_tag[arpre_pkg::PARK_N];
  logic [31:0] k_ip [arpre_pkg::PARK_N];
  bit          k_vld[arpre_pkg::PARK_N];

  arpre_pkg::out_item_t awaited[$];
  int errors;

  function new();
    mac_own = '0;
    ip_own = '0;
    cache_lf = 16'd30000;
    pend_lf = 16'd5000;
    errors = 0;
    foreach (c_vld[i]) begin
      c_vld[i] = 0;
      c_age[i] = 0;
    end
    foreach (p_vld[i]) begin
      p_vld[i] = 0;
      p_age[i] = 0;
    end
    foreach (k_vld[i]) k_vld[i] = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [47:0] val);
    case (idx)
      arpre_pkg::CFG_OWN_MAC: mac_own = val;
      arpre_pkg::CFG_OWN_IP: ip_own = val[31:0];
      arpre_pkg::CFG_CACHE_LF: cache_lf = val[15:0];
      default: pend_lf = val[15:0];
    endcase
  endfunction

  function void push(logic [1:0] kind, logic [47:0] dst, logic [15:0] et,
                     logic [15:0] op, logic [47:0] tmac, logic [31:0] tip,
                     logic [15:0] tag, ref int cnt);
    arpre_pkg::out_item_t r;
    if (cnt >= arpre_pkg::MAX_RES) return;
    r.out_kind = kind;
    r.dst_mac = dst;
    r.ethertype = et;
    r.out_arp_op = op;
    r.out_target_mac = tmac;
    r.out_target_ip = tip;
    r.out_tag = tag;
    r.last = 1'b0;
    awaited.insert(awaited.size(), r);
    cnt++;
  endfunction

  function int unsigned sat_add(int unsigned a, int unsigned d);
    return (a + d > 131071) ? 131071 : a + d;
  endfunction

  // Keeps parked datagrams packed at the front, oldest first.
  function void pack_parked();
    int j;
    j = 0;
    for (int i = 0; i < arpre_pkg::PARK_N; i++)
      if (k_vld[i]) begin
        k_tag[j] = k_tag[i];
        k_ip[j] = k_ip[i];
        j++;
      end
    for (int i = 0; i < arpre_pkg::PARK_N; i++) k_vld[i] = (i < j);
  endfunction

  function void learn(logic [31:0] ip, logic [47:0] mac);
    int idx;
    idx = -1;
    for (int i = 0; i < arpre_pkg::CACHE_N && idx < 0; i++)
      if (c_vld[i] && c_ip[i] == ip) idx = i;
    for (int i = 0; i < arpre_pkg::CACHE_N && idx < 0; i++)
      if (!c_vld[i]) idx = i;
    if (idx < 0) begin
      idx = 0;
      for (int i = 1; i < arpre_pkg::CACHE_N; i++)
        if (c_age[i] > c_age[idx]) idx = i;
    end
    c_ip[idx] = ip;
    c_mac[idx] = mac;
    c_age[idx] = 0;
    c_vld[idx] = 1;
    for (int i = 0; i < arpre_pkg::PEND_N; i++)
      if (p_vld[i] && p_ip[i] == ip) p_vld[i] = 0;
  endfunction

  // Notes an accepted input item and queues the results it should give.
  function void note_item(arpre_pkg::in_item_t it);
    int cnt, pend, pfree, slot;
    bit to_us;
    cnt = 0;
    case (it.req_type)
      arpre_pkg::REQ_SEND: begin
        pend = -1;
        pfree = -1;
        slot = -1;
        for (int i = 0; i < arpre_pkg::CACHE_N; i++)
          if (c_vld[i] && c_ip[i] == it.next_hop_ip && cnt == 0)
            push(arpre_pkg::KIND_IPV4, c_mac[i], arpre_pkg::ET_IPV4, '0, '0, '0,
                 it.datagram_tag, cnt);
        if (cnt == 0) begin
          for (int i = 0; i < arpre_pkg::PEND_N; i++) begin
            if (p_vld[i] && p_ip[i] == it.next_hop_ip && pend < 0) pend = i;
            if (!p_vld[i] && pfree < 0) pfree = i;
          end
          for (int i = arpre_pkg::PARK_N - 1; i >= 0; i--)
            if (!k_vld[i]) slot = i;
          if (slot >= 0 && (pend >= 0 || pfree >= 0)) begin
            k_tag[slot] = it.datagram_tag;
            k_ip[slot] = it.next_hop_ip;
            k_vld[slot] = 1;
            if (pend < 0) begin
              p_ip[pfree] = it.next_hop_ip;
              p_age[pfree] = 0;
              p_vld[pfree] = 1;
              push(arpre_pkg::KIND_ARP_REQ, arpre_pkg::MAC_BCAST, arpre_pkg::ET_ARP,
                   arpre_pkg::ARP_OP_REQ, '0, it.next_hop_ip, '0, cnt);
            end
          end
        end
      end
      arpre_pkg::REQ_RECV: begin
        to_us = (it.frame_dst_mac == mac_own);
        if (to_us || it.frame_dst_mac == arpre_pkg::MAC_BCAST) begin
          if (it.frame_ethertype == arpre_pkg::ET_IPV4) begin
            if (to_us && it.payload_ok)
              push(arpre_pkg::KIND_DELIVER, '0, arpre_pkg::ET_IPV4, '0, '0, '0,
                   it.datagram_tag, cnt);
          end else if (it.frame_ethertype == arpre_pkg::ET_ARP && it.payload_ok &&
                       (it.arp_op == arpre_pkg::ARP_OP_REQ ||
                        it.arp_op == arpre_pkg::ARP_OP_REP)) begin
            learn(it.sender_ip, it.sender_mac);
            if (it.arp_op == arpre_pkg::ARP_OP_REQ && it.target_ip == ip_own)
              push(arpre_pkg::KIND_ARP_REP, it.sender_mac, arpre_pkg::ET_ARP,
                   arpre_pkg::ARP_OP_REP, it.sender_mac, it.sender_ip, '0, cnt);
            // Flushed datagrams go out in arrival order; beyond the result
            // limit they are dropped silently.
            for (int i = 0; i < arpre_pkg::PARK_N; i++)
              if (k_vld[i] && k_ip[i] == it.sender_ip) begin
                push(arpre_pkg::KIND_IPV4, it.sender_mac, arpre_pkg::ET_IPV4, '0, '0,
                     '0, k_tag[i], cnt);
                k_vld[i] = 0;
              end
            pack_parked();
          end
        end
      end
      arpre_pkg::REQ_TICK: begin
        for (int i = 0; i < arpre_pkg::CACHE_N; i++)
          if (c_vld[i]) begin
            c_age[i] = sat_add(c_age[i], it.elapsed_ms);
            if (c_age[i] >= cache_lf) c_vld[i] = 0;
          end
        for (int i = 0; i < arpre_pkg::PEND_N; i++)
          if (p_vld[i]) begin
            p_age[i] = sat_add(p_age[i], it.elapsed_ms);
            if (p_age[i] >= pend_lf) begin
              p_vld[i] = 0;
              for (int k = 0; k < arpre_pkg::PARK_N; k++)
                if (k_vld[k] && k_ip[k] == p_ip[i]) k_vld[k] = 0;
            end
          end
        pack_parked();
      end
      default: ;
    endcase
    if (cnt > 0) awaited[$].last = 1'b1;
  endfunction

  function void check_result(arpre_pkg::out_item_t got);
    arpre_pkg::out_item_t exp;
    if (awaited.size() == 0) begin
      $error("result with nothing awaited: %h", got);
      errors++;
      return;
    end
    exp = awaited.pop_front();
    if (got.out_kind !== exp.out_kind) begin
      $error("out_kind: expected %0d, got %0d", exp.out_kind, got.out_kind);
      errors++;
    end
    if (got.dst_mac !== exp.dst_mac) begin
      $error("dst_mac: expected %h, got %h", exp.dst_mac, got.dst_mac);
      errors++;
    end
    if (got.ethertype !== exp.ethertype) begin
      $error("ethertype: expected %h, got %h", exp.ethertype, got.ethertype);
      errors++;
    end
    if (got.out_arp_op !== exp.out_arp_op) begin
      $error("out_arp_op: expected %h, got %h", exp.out_arp_op, got.out_arp_op);
      errors++;
    end
    if (got.out_target_mac !== exp.out_target_mac) begin
      $error("out_target_mac: expected %h, got %h", exp.out_target_mac,
             got.out_target_mac);
      errors++;
    end
    if (got.out_target_ip !== exp.out_target_ip) begin
      $error("out_target_ip: expected %h, got %h", exp.out_target_ip,
             got.out_target_ip);
      errors++;
    end
    if (got.out_tag !== exp.out_tag) begin
      $error("out_tag: expected %h, got %h", exp.out_tag, got.out_tag);
      errors++;
    end
    if (got.last !== exp.last) begin
      $error("last: expected %b, got %b", exp.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_arp_resolution_engine;
  import arpre_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [47:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;

  arp_resolution_engine dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  arp_result_board board;

  // Idle and stall rates in percent, set per phase by the stimulus process.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // When set, the receiver makes one long hold-off and then clears it.
  bit          hold_off_req;
  longint unsigned cycles = 0;

  // Small pools of addresses so that sends, ARP traffic and ticks meet.
  logic [31:0] hop_pool[12];
  logic [47:0] mac_pool[12];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every accepted result transfer is checked in the same edge at which it
  // is taken, from values sampled before the nonblocking updates land.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
    if (rst_n && in_valid && in_ready) board.note_item(in_data);
  end

  // Receiver side: random stalls, plus one long hold-off when asked for.
  initial begin : receiver
    int unsigned held;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        for (held = 0; held < 400; held++) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  // Offers one item and holds it until the transfer happens. Valid stays
  // high straight into the next item when there is no gap.
  task automatic offer(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every awaited result has arrived, then covers the engine's
  // own tail for items that give no result.
  task automatic drain();
    drop_valid();
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic in_item_t rand_noise();
    in_item_t it;
    logic [287:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom};
    it = bits[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t mk_send(logic [31:0] hop, logic [15:0] tag);
    in_item_t it;
    it = rand_noise();
    it.req_type = REQ_SEND;
    it.next_hop_ip = hop;
    it.datagram_tag = tag;
    return it;
  endfunction

  function automatic in_item_t mk_arp(logic [47:0] dst, logic [15:0] op,
                                      logic [31:0] sip, logic [47:0] smac,
                                      logic [31:0] tip);
    in_item_t it;
    it = rand_noise();
    it.req_type = REQ_RECV;
    it.frame_dst_mac = dst;
    it.frame_ethertype = ET_ARP;
    it.payload_ok = 1'b1;
    it.arp_op = op;
    it.sender_ip = sip;
    it.sender_mac = smac;
    it.target_ip = tip;
    return it;
  endfunction

  function automatic in_item_t mk_tick(logic [15:0] ms);
    in_item_t it;
    it = rand_noise();
    it.req_type = REQ_TICK;
    it.elapsed_ms = ms;
    return it;
  endfunction

  // A random item biased towards well-formed exchanges on the pooled
  // addresses, with some noise and broken frames mixed in.
  function automatic in_item_t rand_item();
    in_item_t it;
    int unsigned sel, k;
    sel = $urandom_range(99);
    k = $urandom_range(11);
    if (sel < 35) begin
      it = mk_send(hop_pool[k], 16'($urandom));
    end else if (sel < 60) begin
      it = mk_arp(($urandom_range(1) != 0) ? board.mac_own : MAC_BCAST,
                  ($urandom_range(1) != 0) ? ARP_OP_REQ : ARP_OP_REP, hop_pool[k],
                  mac_pool[$urandom_range(11)],
                  ($urandom_range(2) == 0) ? $urandom : board.ip_own);
    end else if (sel < 72) begin
      it = mk_tick($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1500)));
    end else if (sel < 82) begin
      it = mk_arp(board.mac_own, 16'(0), hop_pool[k], mac_pool[k], board.ip_own);
      it.frame_ethertype = ET_IPV4;
      it.payload_ok = $urandom_range(3) != 0;
      if ($urandom_range(3) == 0) it.frame_dst_mac = MAC_BCAST;
    end else if (sel < 92) begin
      it = mk_arp(board.mac_own, ARP_OP_REQ, hop_pool[k], mac_pool[k], board.ip_own);
      case ($urandom_range(3))
        0: it.payload_ok = 1'b0;
        1: it.arp_op = $urandom_range(2) == 0 ? 16'd0 : 16'($urandom_range(3, 65535));
        2: it.frame_dst_mac = 48'({$urandom, $urandom});
        default: it.frame_ethertype = 16'($urandom);
      endcase
    end else begin
      it = rand_noise();
      if (it.req_type == 2'd3 && $urandom_range(1) == 0) it.req_type = REQ_SEND;
    end
    return it;
  endfunction

  task automatic random_phase(int unsigned n, int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) offer(rand_item());
    drain();
  endtask

  initial begin : stimulus
    in_item_t it;
    board = new();
    rst_n = 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_OWN_MAC;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b0;
    foreach (hop_pool[i]) begin
      hop_pool[i] = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
      mac_pool[i] = (i == 0) ? 48'h0 : (i == 1) ? 48'hFFFF_FFFF_FFFE :
                    48'({$urandom, $urandom});
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset values of the registers first: an unknown
    // request type, two misses to one hop, then a reply that resolves them.
    it = rand_noise();
    it.req_type = 2'd3;
    offer(it);
    offer(mk_send(32'hFFFF_FFFF, 16'hFFFF));
    offer(mk_send(32'hFFFF_FFFF, 16'h0000));
    offer(mk_arp(MAC_BCAST, ARP_OP_REP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFE, '0));
    offer(mk_send(32'hFFFF_FFFF, 16'h1234));
    drain();

    write_reg(CFG_OWN_MAC, 48'h0200_0000_0001);
    write_reg(CFG_OWN_IP, 48'hC0A8_0001);
    write_reg(CFG_CACHE_LF, 48'd1);
    write_reg(CFG_PEND_LF, 48'd65535);
    // A request for our address, and an IPv4 delivery good and broken.
    offer(mk_arp(48'h0200_0000_0001, ARP_OP_REQ, 32'h0A00_0001, 48'h0, 32'hC0A8_0001));
    it = mk_arp(48'h0200_0000_0001, '0, '0, '0, '0);
    it.frame_ethertype = ET_IPV4;
    offer(it);
    it.payload_ok = 1'b0;
    offer(it);
    it.payload_ok = 1'b1;
    it.frame_dst_mac = MAC_BCAST;
    offer(it);
    // Cache life of one expires on any non-zero tick; a zero tick keeps it.
    offer(mk_tick(16'd0));
    offer(mk_send(32'h0A00_0001, 16'hA5A5));
    offer(mk_tick(16'hFFFF));
    offer(mk_tick(16'hFFFF));
    offer(mk_tick(16'hFFFF));
    // Fill the pending table and the parked queue past their limits.
    for (int i = 0; i < 10; i++) offer(mk_send(32'h0B00_0000 + i, 16'(i)));
    for (int i = 0; i < 10; i++) offer(mk_send(32'h0B00_0000, 16'(100 + i)));
    drain();

    // Flush more than one parked datagram with a reply leading the batch.
    offer(mk_arp(MAC_BCAST, ARP_OP_REQ, 32'h0B00_0000, 48'hFFFF_FFFF_FFFF, 32'hC0A8_0001));
    drain();
    write_reg(CFG_CACHE_LF, 48'd65535);
    write_reg(CFG_PEND_LF, 48'd1);
    offer(mk_tick(16'd1));
    // Overfill the cache so that the oldest entry is replaced.
    for (int i = 0; i < 18; i++) begin
      offer(mk_arp(MAC_BCAST, ARP_OP_REP, 32'h0C00_0000 + i, 48'({$urandom, $urandom}),
                   '0));
      if (i % 4 == 0) offer(mk_tick(16'(i)));
    end
    drain();

    // Random part over several register settings and idling phases.
    write_reg(CFG_OWN_MAC, 48'({$urandom, $urandom}));
    write_reg(CFG_OWN_IP, 48'(hop_pool[2]));
    write_reg(CFG_CACHE_LF, 48'd4000);
    write_reg(CFG_PEND_LF, 48'd2500);
    random_phase(40, 0, 0);
    random_phase(40, 54, 0);
    write_reg(CFG_PEND_LF, 48'd65535);
    write_reg(CFG_CACHE_LF, 48'd1);
    write_reg(CFG_OWN_IP, 48'hFFFF_FFFF);
    random_phase(35, 0, 54);
    write_reg(CFG_CACHE_LF, 48'd30000);
    write_reg(CFG_PEND_LF, 48'd5000);
    write_reg(CFG_OWN_MAC, 48'h0);
    write_reg(CFG_OWN_IP, 48'(hop_pool[3]));
    random_phase(35, 38, 38);

    // Long receiver hold-off while items keep coming, so that the engine
    // backs up and stops taking input.
    hold_off_req = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 50; i++) offer(rand_item());
    drain();

    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Generous run limit: every item at sixteen stalled results and the
  // longest table walks, several times over.
  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end
endmodule
